### rtl/dpfp_pkg.sv
// Package: conversion mode codes and pixel expansion functions for the pixel format packer.
package dpfp_pkg;

  // Conversion modes; the two unused codes pass bytes through unchanged
  typedef enum logic [2:0] {
    MODE_ASIS   = 3'd0,
    MODE_SWAP16 = 3'd1,
    MODE_RGB444 = 3'd2,
    MODE_RGB332 = 3'd3,
    MODE_GRAY8  = 3'd4,
    MODE_GRAY4  = 3'd5
  } mode_t;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW     = 3;
  localparam logic [0:0]  AddrMode = 1'b0;

  // Widen RGB332 to RGB565 by bit replication
  function automatic logic [15:0] rgb332_to_565(input logic [7:0] v);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = {v[7:5], v[7:6]};
    g6 = {v[4:2], v[4:2]};
    b5 = {v[1:0], v[1:0], v[1]};
    return {r5, g6, b5};
  endfunction

  // Spread one 8-bit gray level over all three channels
  function automatic logic [15:0] gray8_to_565(input logic [7:0] v);
    return {v[7:3], v[7:2], v[7:3]};
  endfunction

  // Spread one 4-bit gray level over all three channels
  function automatic logic [15:0] gray4_to_565(input logic [3:0] nib);
    logic [5:0] g6;
    logic [4:0] g5;
    g6 = {nib, nib[3:2]};
    g5 = {nib, nib[3]};
    return {g5, g6, g5};
  endfunction

endpackage

### rtl/display_pixel_format_packer.sv
// Top level: pixel format packer with stream input, stream output and APB mode register.
//
// Usage:
//   Source bytes enter on the in_ stream, one byte per beat, with in_tlast on
//   the final byte of a frame. Converted link bytes leave on the out_ stream;
//   out_tlast marks the final byte caused by one source byte, and out_tuser
//   is high on the final byte of the frame. The conversion mode is written
//   through the APB port at address 0 while the block is idle.
//   The first result byte of a source byte is registered and valid the cycle after
//   the source beat is accepted. A source byte causes zero to four result
//   beats (four in gray4 mode, two in the RGB565 expansion modes), and the
//   output side moves one beat per cycle while out_tready is high, draining
//   them from the byte-wide result register. A new source byte is taken in
//   the cycle the last pending result beat leaves.
//   Reset clears the mode to pass-through, empties the result register and
//   clears all pairing state. When the receiver stalls, the result register
//   holds its beat and in_tready stays low until it drains.
module display_pixel_format_packer (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tlast,   // frame_last
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] link_byte
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser,  // [0] frame_end
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned NB = dpfp_pkg::MaxBytes;
  localparam int unsigned CW = dpfp_pkg::CntW;

  logic [2:0]          mode_r;
  logic [7:0]          held_low_r,  held_low_nxt;
  logic                phase_r,     phase_nxt;
  logic                parity_r,    parity_nxt;
  logic [3:0]          blue_r,      blue_nxt;
  logic [7:0]          buf_r [NB];
  logic [7:0]          buf_nxt [NB];
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       gen_cnt;
  logic                fend_r;
  logic                in_fire, out_fire, cfg_wr;
  logic [15:0]         pix_a, pix_b;
  logic [15:0]         pix444;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == dpfp_pkg::AddrMode) ? {29'd0, mode_r} : 32'd0;

  // Output side shows the head of the result register
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[0];
  assign out_tlast  = (cnt_r == CW'(1));
  assign out_tuser  = fend_r && (cnt_r == CW'(1));
  assign out_fire   = out_tvalid && out_tready;

  // Take a new beat once the last pending result leaves
  assign in_tready = (cnt_r == '0) || ((cnt_r == CW'(1)) && out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // Convert one source byte into up to four result bytes and the next state
  always_comb begin
    held_low_nxt = held_low_r;
    phase_nxt    = phase_r;
    parity_nxt   = parity_r;
    blue_nxt     = blue_r;
    gen_cnt      = '0;
    for (int i = 0; i < NB; i++) begin
      buf_nxt[i] = 8'd0;
    end
    pix444 = {in_tdata, held_low_r};
    pix_a  = dpfp_pkg::rgb332_to_565(in_tdata);
    pix_b  = dpfp_pkg::gray8_to_565(in_tdata);
    case (mode_r)
      dpfp_pkg::MODE_SWAP16: begin
        if (!phase_r) begin
          held_low_nxt = in_tdata;
          phase_nxt    = 1'b1;
        end else begin
          buf_nxt[0] = in_tdata;
          buf_nxt[1] = held_low_r;
          gen_cnt    = CW'(2);
          phase_nxt  = 1'b0;
        end
      end
      dpfp_pkg::MODE_RGB444: begin
        if (!phase_r) begin
          held_low_nxt = in_tdata;
          phase_nxt    = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (!parity_r) begin
            buf_nxt[0] = {pix444[15:12], pix444[10:7]};
            gen_cnt    = CW'(1);
            blue_nxt   = pix444[4:1];
            parity_nxt = 1'b1;
          end else begin
            buf_nxt[0] = {blue_r, pix444[15:12]};
            buf_nxt[1] = {pix444[10:7], pix444[4:1]};
            gen_cnt    = CW'(2);
            parity_nxt = 1'b0;
          end
        end
        // Pad an odd trailing pixel with its blue nibble
        if (in_tlast && parity_nxt) begin
          buf_nxt[gen_cnt[1:0]] = {blue_nxt, 4'd0};
          gen_cnt = gen_cnt + CW'(1);
        end
      end
      dpfp_pkg::MODE_RGB332: begin
        buf_nxt[0] = pix_a[15:8];
        buf_nxt[1] = pix_a[7:0];
        gen_cnt    = CW'(2);
      end
      dpfp_pkg::MODE_GRAY8: begin
        buf_nxt[0] = pix_b[15:8];
        buf_nxt[1] = pix_b[7:0];
        gen_cnt    = CW'(2);
      end
      dpfp_pkg::MODE_GRAY4: begin
        pix_a      = dpfp_pkg::gray4_to_565(in_tdata[7:4]);
        pix_b      = dpfp_pkg::gray4_to_565(in_tdata[3:0]);
        buf_nxt[0] = pix_a[15:8];
        buf_nxt[1] = pix_a[7:0];
        buf_nxt[2] = pix_b[15:8];
        buf_nxt[3] = pix_b[7:0];
        gen_cnt    = CW'(4);
      end
      default: begin
        buf_nxt[0] = in_tdata;
        gen_cnt    = CW'(1);
      end
    endcase
    // Clear pairing and parity at frame end
    if (in_tlast) begin
      phase_nxt  = 1'b0;
      parity_nxt = 1'b0;
    end
  end

  // Hold mode, pairing state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= dpfp_pkg::MODE_ASIS;
      held_low_r <= 8'd0;
      phase_r    <= 1'b0;
      parity_r   <= 1'b0;
      blue_r     <= 4'd0;
      cnt_r      <= '0;
      fend_r     <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr == dpfp_pkg::AddrMode)) begin
        mode_r <= cfg_pwdata[2:0];
      end
      if (in_fire) begin
        held_low_r <= held_low_nxt;
        phase_r    <= phase_nxt;
        parity_r   <= parity_nxt;
        blue_r     <= blue_nxt;
        cnt_r      <= gen_cnt;
        fend_r     <= in_tlast;
      end else if (out_fire) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Load result bytes, or advance by one on each output beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < NB; i++) begin
        buf_r[i] <= buf_nxt[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < NB - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
      buf_r[NB-1] <= 8'd0;
    end
  end

endmodule
